// File: sv/tccd_pkg.sv
// Shared types, constants and helpers of the telecine cadence detector.
// No dependencies; every other file of the block but tccd_queue uses this package.
`timescale 1ns / 1ps

package tccd_pkg;

  // Field and register widths.
  localparam int LUMA_W      = 8;
  localparam int SQ_W        = 2 * LUMA_W;
  localparam int SIZE_W      = 13;
  localparam int RATIO_W     = 8;
  localparam int BIN_W       = 64;
  localparam int PHASE_OUT_W = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  // Default structure of the block.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_PHASES     = 5;
  localparam int QUEUE_DEPTH    = 8;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH   = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT  = SIZE_W'(1080);
  localparam logic [RATIO_W-1:0] RST_RATIO_INVERSE = RATIO_W'(10);

  // Opcodes of an input item.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_RATIO_INVERSE = 2'd2
  } reg_idx_t;

  // One verdict as it leaves the back end.
  typedef struct packed {
    logic                   detected;
    logic [PHASE_OUT_W-1:0] even_phase;
    logic [PHASE_OUT_W-1:0] odd_phase;
  } res_t;

  // Add that sticks at the all-ones value instead of wrapping.
  function automatic logic [BIN_W-1:0] sat_add(input logic [BIN_W-1:0] a,
                                               input logic [BIN_W-1:0] b);
    logic [BIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BIN_W] ? {BIN_W{1'b1}} : s[BIN_W-1:0];
  endfunction

endpackage

// File: sv/telecine_cadence_field_ssd_detector_core.sv
// Top level of the 3:2 pulldown cadence detector: register port, front end,
// queue and back end. Depends on tccd_pkg, tccd_front, tccd_queue, tccd_back.
//
//   Channel   Ports                                         Transfer when
//   input     push, full, in_opcode, in_cur_luma,           push && !full
//             in_prev_luma
//   result    empty, pop, out_detected, out_even_phase,     pop && !empty
//             out_odd_phase
//   config    psel, penable, pwrite, paddr, pwdata,         psel && penable &&
//             prdata, pready                                pwrite
//
// Pixel items are taken one per clock while full is low; the back end adds
// one squared difference into its bins per cycle while it accumulates and
// the queue holds an item. An end item holds the back end while it takes the
// item, sweeps and clears the bins, multiplies, and loads the result register.
// Pixels arriving meanwhile wait in the queue of QUEUE_DEPTH entries, which
// drains only while the back end accumulates; once it fills, full stalls input.
// Reset is synchronous; the bins start at zero with no clearing pass.
// A waiting result stalls the back end at its final step, and so the input
// once the queue has filled behind it.
`timescale 1ns / 1ps

module telecine_cadence_field_ssd_detector_core #(
  parameter int MAX_WIDTH  = tccd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tccd_pkg::DEF_MAX_HEIGHT,
  parameter int PHASES     = tccd_pkg::DEF_PHASES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel.
  input  logic                             push,
  output logic                             full,
  input  logic                             in_opcode,
  input  logic [tccd_pkg::LUMA_W-1:0]      in_cur_luma,
  input  logic [tccd_pkg::LUMA_W-1:0]      in_prev_luma,
  // Result channel.
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_detected,
  output logic [tccd_pkg::PHASE_OUT_W-1:0] out_even_phase,
  output logic [tccd_pkg::PHASE_OUT_W-1:0] out_odd_phase,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tccd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tccd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tccd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  import tccd_pkg::*;

  localparam int PW = $clog2(PHASES);
  localparam int QW = 2 + PW + SQ_W;

  logic [SIZE_W-1:0]  frame_width_r, frame_width_nxt;
  logic [SIZE_W-1:0]  frame_height_r, frame_height_nxt;
  logic [RATIO_W-1:0] ratio_inverse_r, ratio_inverse_nxt;
  logic               cfg_wr;
  logic               in_accept;
  logic               q_wr, q_rd, q_full, q_empty;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic               res_valid;
  res_t               res;

  // Register writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt   = frame_width_r;
    frame_height_nxt  = frame_height_r;
    ratio_inverse_nxt = ratio_inverse_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:   frame_width_nxt   = pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_nxt  = pwdata[SIZE_W-1:0];
        REG_RATIO_INVERSE: ratio_inverse_nxt = pwdata[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:   prdata = APB_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(frame_height_r);
      REG_RATIO_INVERSE: prdata = APB_DATA_W'(ratio_inverse_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      ratio_inverse_r <= RST_RATIO_INVERSE;
    end else begin
      frame_width_r   <= frame_width_nxt;
      frame_height_r  <= frame_height_nxt;
      ratio_inverse_r <= ratio_inverse_nxt;
    end
  end

  // Input transfer happens whenever the queue has room.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  tccd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PHASES     (PHASES),
    .QW         (QW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .opcode       (in_opcode),
    .cur_luma     (in_cur_luma),
    .prev_luma    (in_prev_luma),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_wr         (q_wr),
    .q_data       (q_wdata)
  );

  tccd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  tccd_back #(
    .PHASES (PHASES),
    .QW     (QW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_rd          (q_rd),
    .ratio_inverse (ratio_inverse_r),
    .res_pop       (pop),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Result channel.
  assign empty          = !res_valid;
  assign out_detected   = res.detected;
  assign out_even_phase = res.even_phase;
  assign out_odd_phase  = res.odd_phase;

endmodule

// File: sv/tccd_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module tccd_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  // Status and transfer qualification.
  assign q_full  = (cnt_r == (AW+1)'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: sv/tccd_front.sv
// Front end: raster position tracking, squared difference and bin selection.
// Depends on tccd_pkg; feeds tccd_queue.
`timescale 1ns / 1ps

module tccd_front #(
  parameter int MAX_WIDTH  = tccd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tccd_pkg::DEF_MAX_HEIGHT,
  parameter int PHASES     = tccd_pkg::DEF_PHASES,
  parameter int QW         = 2 + $clog2(PHASES) + 2 * tccd_pkg::LUMA_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        opcode,
  input  logic [tccd_pkg::LUMA_W-1:0] cur_luma,
  input  logic [tccd_pkg::LUMA_W-1:0] prev_luma,
  input  logic [tccd_pkg::SIZE_W-1:0] frame_width,
  input  logic [tccd_pkg::SIZE_W-1:0] frame_height,
  output logic                        q_wr,
  output logic [QW-1:0]               q_data
);

  import tccd_pkg::*;

  localparam int PW  = $clog2(PHASES);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EWW = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int EHW = (HW > SIZE_W) ? HW : SIZE_W;

  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [PW-1:0]     phase_r, phase_nxt;
  logic              first_r, first_nxt;
  logic [WW-1:0]     w_lim;
  logic [HW-1:0]     h_lim;
  logic              col_last, row_last;
  logic [LUMA_W:0]   diff;
  logic [LUMA_W-1:0] mag;
  logic [SQ_W-1:0]   sq;

  // Clamp the configured size to 1..MAX.
  always_comb begin
    if (frame_width == '0) begin
      w_lim = WW'(1);
    end else if (EWW'(frame_width) > EWW'(MAX_WIDTH)) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_lim = HW'(1);
    end else if (EHW'(frame_height) > EHW'(MAX_HEIGHT)) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(frame_height);
    end
  end

  // A counter at or past the limit wraps, which also covers a size change.
  assign col_last = ((WW+1)'(col_r) + 1'b1) >= (WW+1)'(w_lim);
  assign row_last = ((HW+1)'(row_r) + 1'b1) >= (HW+1)'(h_lim);

  // Squared difference of the two samples.
  always_comb begin
    diff = {1'b0, cur_luma} - {1'b0, prev_luma};
    mag  = diff[LUMA_W] ? LUMA_W'(-diff) : LUMA_W'(diff);
    sq   = SQ_W'(mag) * SQ_W'(mag);
  end

  // Raster position, frame phase and the first-frame flag.
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    if (accept) begin
      if (opcode == OP_END) begin
        col_nxt   = '0;
        row_nxt   = '0;
        phase_nxt = '0;
        first_nxt = 1'b1;
      end else if (col_last) begin
        col_nxt = '0;
        if (row_last) begin
          row_nxt   = '0;
          phase_nxt = (phase_r == PW'(PHASES - 1)) ? '0 : phase_r + 1'b1;
          first_nxt = 1'b0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
    end
  end

  // Frame zero adds nothing, so only useful work enters the queue.
  assign q_wr   = accept && ((opcode == OP_END) || !first_r);
  assign q_data = {opcode, row_r[0], phase_r, sq};

endmodule

// File: sv/tccd_back.sv
// Back end: phase bins, minimum and total sweep, ratio test and result register.
// Depends on tccd_pkg; reads from tccd_queue.
`timescale 1ns / 1ps

module tccd_back #(
  parameter int PHASES = tccd_pkg::DEF_PHASES,
  parameter int QW     = 2 + $clog2(PHASES) + 2 * tccd_pkg::LUMA_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  logic [QW-1:0]                q_data,
  output logic                         q_rd,
  input  logic [tccd_pkg::RATIO_W-1:0] ratio_inverse,
  input  logic                         res_pop,
  output logic                         res_valid,
  output tccd_pkg::res_t               res
);

  import tccd_pkg::*;

  localparam int PW = $clog2(PHASES);
  localparam int PRODW = BIN_W + RATIO_W;

  typedef enum logic [3:0] {
    ST_ACC   = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_MULT  = 4'b0100,
    ST_DONE  = 4'b1000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [BIN_W-1:0] even_r [PHASES];
  logic [BIN_W-1:0] even_nxt [PHASES];
  logic [BIN_W-1:0] odd_r [PHASES];
  logic [BIN_W-1:0] odd_nxt [PHASES];
  logic [PW-1:0]    k_r, k_nxt;
  logic [BIN_W-1:0] tot_e_r, tot_e_nxt, tot_o_r, tot_o_nxt;
  logic [BIN_W-1:0] best_e_r, best_e_nxt, best_o_r, best_o_nxt;
  logic [PW-1:0]    idx_e_r, idx_e_nxt, idx_o_r, idx_o_nxt;
  logic [PRODW-1:0] prod_e_r, prod_e_nxt, prod_o_r, prod_o_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic             e_end, e_odd;
  logic [PW-1:0]    e_phase;
  logic [SQ_W-1:0]  e_sq;
  logic [RATIO_W-1:0] r_eff;
  logic             pass_e, pass_o;

  // Unpack the queue head.
  assign e_end   = q_data[QW-1];
  assign e_odd   = q_data[QW-2];
  assign e_phase = q_data[SQ_W +: PW];
  assign e_sq    = q_data[SQ_W-1:0];

  assign r_eff  = (ratio_inverse == '0) ? RATIO_W'(1) : ratio_inverse;
  // min * r < total is the same test as min <= (total - 1) / r.
  assign pass_e = (tot_e_r == '0) || (prod_e_r < PRODW'(tot_e_r));
  assign pass_o = (tot_o_r == '0) || (prod_o_r < PRODW'(tot_o_r));

  // Sequencer: accumulate, sweep the bins out, multiply, post the verdict.
  always_comb begin
    state_nxt  = state_r;
    even_nxt   = even_r;
    odd_nxt    = odd_r;
    k_nxt      = k_r;
    tot_e_nxt  = tot_e_r;
    tot_o_nxt  = tot_o_r;
    best_e_nxt = best_e_r;
    best_o_nxt = best_o_r;
    idx_e_nxt  = idx_e_r;
    idx_o_nxt  = idx_o_r;
    prod_e_nxt = prod_e_r;
    prod_o_nxt = prod_o_r;
    res_nxt    = res_r;
    q_rd       = 1'b0;
    out_valid_nxt = out_valid_r && !res_pop;
    case (state_r)
      ST_ACC: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          if (e_end == OP_END) begin
            state_nxt  = ST_SWEEP;
            k_nxt      = '0;
            tot_e_nxt  = '0;
            tot_o_nxt  = '0;
            best_e_nxt = '1;
            best_o_nxt = '1;
            idx_e_nxt  = '0;
            idx_o_nxt  = '0;
          end else if (e_odd) begin
            odd_nxt[e_phase] = sat_add(odd_r[e_phase], BIN_W'(e_sq));
          end else begin
            even_nxt[e_phase] = sat_add(even_r[e_phase], BIN_W'(e_sq));
          end
        end
      end
      ST_SWEEP: begin
        // Bins shift toward index zero and zeros fill in behind, so the
        // sweep also clears them.
        tot_e_nxt = sat_add(tot_e_r, even_r[0]);
        tot_o_nxt = sat_add(tot_o_r, odd_r[0]);
        if (even_r[0] < best_e_r) begin
          best_e_nxt = even_r[0];
          idx_e_nxt  = k_r;
        end
        if (odd_r[0] < best_o_r) begin
          best_o_nxt = odd_r[0];
          idx_o_nxt  = k_r;
        end
        for (int i = 0; i < PHASES - 1; i++) begin
          even_nxt[i] = even_r[i+1];
          odd_nxt[i]  = odd_r[i+1];
        end
        even_nxt[PHASES-1] = '0;
        odd_nxt[PHASES-1]  = '0;
        k_nxt = k_r + 1'b1;
        if (k_r == PW'(PHASES - 1)) begin
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: begin
        prod_e_nxt = PRODW'(best_e_r) * PRODW'(r_eff);
        prod_o_nxt = PRODW'(best_o_r) * PRODW'(r_eff);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || res_pop) begin
          res_nxt.detected   = pass_e && pass_o;
          res_nxt.even_phase = PHASE_OUT_W'(idx_e_r);
          res_nxt.odd_phase  = PHASE_OUT_W'(idx_o_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  // Control state and bins, which must start at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < PHASES; i++) begin
        even_r[i] <= '0;
        odd_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      even_r      <= even_nxt;
      odd_r       <= odd_nxt;
    end
  end

  // Working values of the sweep and the result payload.
  always_ff @(posedge clk) begin
    tot_e_r  <= tot_e_nxt;
    tot_o_r  <= tot_o_nxt;
    best_e_r <= best_e_nxt;
    best_o_r <= best_o_nxt;
    idx_e_r  <= idx_e_nxt;
    idx_o_r  <= idx_o_nxt;
    prod_e_r <= prod_e_nxt;
    prod_o_r <= prod_o_nxt;
    res_r    <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

// File: sv/tccd_checker.sv
// Port-level checks of the cadence detector, bound to the top level.
// Depends on tccd_pkg and telecine_cadence_field_ssd_detector_core.
`timescale 1ns / 1ps

module tccd_checker #(
  parameter int PHASES = tccd_pkg::DEF_PHASES
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             push,
  input logic                             full,
  input logic                             pop,
  input logic                             empty,
  input logic                             out_detected,
  input logic [tccd_pkg::PHASE_OUT_W-1:0] out_even_phase,
  input logic [tccd_pkg::PHASE_OUT_W-1:0] out_odd_phase
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result channel not empty after reset");

  // Reset leaves the input queue with room.
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input channel full after reset");

  // A reported phase names one of the bins.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (32'(out_even_phase) < PHASES) && (32'(out_odd_phase) < PHASES))
    else $error("reported phase beyond the bin count");

  // A result not yet taken stays on the ports unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_detected) &&
      $stable(out_even_phase) && $stable(out_odd_phase))
    else $error("waiting result changed or vanished before its transfer");

endmodule

bind telecine_cadence_field_ssd_detector_core tccd_checker #(
  .PHASES (PHASES)
) u_tccd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .pop            (pop),
  .empty          (empty),
  .out_detected   (out_detected),
  .out_even_phase (out_even_phase),
  .out_odd_phase  (out_odd_phase)
);
